/* rtl/core/cel_pkg.sv */
// Shared constants and the log table generator for the cross-entropy block.
package cel_pkg;

	localparam int DATA_WIDTH_DEF     = 16;
	localparam int FRAC_BITS_DEF      = 12;
	localparam int LOG_TABLE_BITS_DEF = 8;
	localparam int MIN_PREDICTION_DEF = 1;
	localparam int QUEUE_DEPTH_DEF    = 4;

	localparam int ACC_W    = 48;
	localparam int LOSS_W   = 40;
	localparam int LN_ENT_W = 16;

	localparam int                LN2_Q16 = 45426;
	localparam longint unsigned   LN2_Q32 = 64'd2977044472;

	// signed width of ln(p) in Q.16 for p in [1 LSB, 1.0]
	function automatic int ln_width(input int frac_bits);
		return $clog2((frac_bits + 1) * LN2_Q16) + 1;
	endfunction

	// queue entry: gradient, actual, ln, last
	function automatic int q_width(input int data_width, input int frac_bits);
		return 2 * data_width + 2 + ln_width(frac_bits);
	endfunction

	// ln(1 + idx/2^tbits) in Q.16 by bitwise log2 then scaling by ln2
	function automatic logic [LN_ENT_W-1:0] ln_entry(input int idx, input int tbits);
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] r;
		x = (64'd1 << 30) + (64'(idx) << (30 - tbits));
		y = '0;
		for (int b = 1; b <= 32; b++) begin
			x = (x * x) >> 30;
			if (x >= (64'd2 << 30)) begin
				x = x >> 1;
				y = y | (64'd1 << (32 - b));
			end
		end
		r = (y * LN2_Q32 + (64'd1 << 47)) >> 48;
		return r[LN_ENT_W-1:0];
	endfunction

endpackage

/* rtl/core/cross_entropy_loss_gradient.sv */
// Top level of the cross-entropy loss and gradient block.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------------
//   in      | request   | in_valid / in_stall | prediction, actual, last_element
//   out     | result    | out_valid/out_stall | gradient, loss, loss_valid
//
// One request a cycle is sustained while out_stall stays low; each result passes through
// the front register, the queue, the multiplier stage, the accumulate stage and the
// output register.
// Reset clears valid flags, queue pointers and the running sum; payload is not reset.
// A held result (out_stall high) holds the whole back end; the queue of QUEUE_DEPTH
// entries and the front register then fill, and in_stall rises once both are full.
module cross_entropy_loss_gradient #(
	parameter int DATA_WIDTH     = cel_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS      = cel_pkg::FRAC_BITS_DEF,
	parameter int LOG_TABLE_BITS = cel_pkg::LOG_TABLE_BITS_DEF,
	parameter int MIN_PREDICTION = cel_pkg::MIN_PREDICTION_DEF,
	parameter int QUEUE_DEPTH    = cel_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [DATA_WIDTH-1:0]      prediction,
	input  logic signed [DATA_WIDTH-1:0]      actual,
	input  logic                              last_element,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [DATA_WIDTH:0]        gradient,
	output logic signed [cel_pkg::LOSS_W-1:0] loss,
	output logic                              loss_valid
);

	localparam int Q_W = cel_pkg::q_width(DATA_WIDTH, FRAC_BITS);

	logic           push_valid;
	logic           push_stall;
	logic [Q_W-1:0] push_data;
	logic           pop_valid;
	logic           pop_stall;
	logic [Q_W-1:0] pop_data;

	cel_front #(
		.DATA_WIDTH     (DATA_WIDTH),
		.FRAC_BITS      (FRAC_BITS),
		.LOG_TABLE_BITS (LOG_TABLE_BITS),
		.MIN_PREDICTION (MIN_PREDICTION)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.prediction   (prediction),
		.actual       (actual),
		.last_element (last_element),
		.push_valid   (push_valid),
		.push_stall   (push_stall),
		.push_data    (push_data)
	);

	cel_queue #(
		.WIDTH (Q_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_stall  (pop_stall),
		.pop_data   (pop_data)
	);

	cel_back #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_stall  (pop_stall),
		.pop_data   (pop_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.gradient   (gradient),
		.loss       (loss),
		.loss_valid (loss_valid)
	);

endmodule

/* rtl/core/cel_front.sv */
// Front end: takes requests, clamps the prediction and forms gradient and ln(p).
module cel_front #(
	parameter int DATA_WIDTH     = cel_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS      = cel_pkg::FRAC_BITS_DEF,
	parameter int LOG_TABLE_BITS = cel_pkg::LOG_TABLE_BITS_DEF,
	parameter int MIN_PREDICTION = cel_pkg::MIN_PREDICTION_DEF
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              in_valid,
	output logic                                              in_stall,
	input  logic signed [DATA_WIDTH-1:0]                      prediction,
	input  logic signed [DATA_WIDTH-1:0]                      actual,
	input  logic                                              last_element,
	output logic                                              push_valid,
	input  logic                                              push_stall,
	output logic [cel_pkg::q_width(DATA_WIDTH, FRAC_BITS)-1:0] push_data
);

	localparam int LN_W  = cel_pkg::ln_width(FRAC_BITS);
	localparam int PC_W  = FRAC_BITS + 1;
	localparam int CMP_W = (DATA_WIDTH > FRAC_BITS + 2) ? DATA_WIDTH : FRAC_BITS + 2;
	localparam int K_W   = $clog2(PC_W);
	localparam int TAB_N = 1 << LOG_TABLE_BITS;
	localparam int SH_W  = PC_W + LOG_TABLE_BITS;

	localparam logic signed [CMP_W-1:0] P_MIN = CMP_W'(MIN_PREDICTION);
	localparam logic signed [CMP_W-1:0] P_ONE = CMP_W'(64'd1 << FRAC_BITS);

	logic                          adv;
	logic signed [CMP_W-1:0]       p_ext;
	logic [PC_W-1:0]               pc;
	logic                          valid_s1;
	logic [PC_W-1:0]               pc_s1;
	logic signed [DATA_WIDTH-1:0]  pred_s1;
	logic signed [DATA_WIDTH-1:0]  act_s1;
	logic                          last_s1;
	logic signed [DATA_WIDTH:0]    grad;
	logic [K_W-1:0]                k;
	logic [K_W-1:0]                dk;
	logic [SH_W-1:0]               sh;
	logic [LOG_TABLE_BITS-1:0]     m;
	logic [LN_W-1:0]               ln;
	logic [cel_pkg::LN_ENT_W-1:0]  ln_tab [TAB_N];

	for (genvar i = 0; i < TAB_N; i++) begin : g_tab
		localparam logic [cel_pkg::LN_ENT_W-1:0] ENTRY = cel_pkg::ln_entry(i, LOG_TABLE_BITS);
		assign ln_tab[i] = ENTRY;
	end

	assign adv      = !valid_s1 || !push_stall;
	assign in_stall = !adv;

	assign p_ext = CMP_W'(prediction);

	always_comb begin
		if (p_ext < P_MIN) begin
			pc = PC_W'(P_MIN);
		end else if (p_ext > P_ONE) begin
			pc = PC_W'(P_ONE);
		end else begin
			pc = PC_W'(p_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			pc_s1   <= pc;
			pred_s1 <= prediction;
			act_s1  <= actual;
			last_s1 <= last_element;
		end
	end

	assign grad = (DATA_WIDTH + 1)'(pred_s1) - (DATA_WIDTH + 1)'(act_s1);

	// leading-one position of the clamped prediction
	always_comb begin
		k = '0;
		for (int i = 0; i < PC_W; i++) begin
			if (pc_s1[i]) begin
				k = K_W'(i);
			end
		end
	end

	// mantissa bits just below the leading one, zero-filled
	assign sh = {pc_s1, {LOG_TABLE_BITS{1'b0}}} >> k;
	assign m  = sh[LOG_TABLE_BITS-1:0];
	assign dk = K_W'(FRAC_BITS) - k;
	assign ln = LN_W'(ln_tab[m]) - LN_W'(dk) * LN_W'(cel_pkg::LN2_Q16);

	assign push_valid = valid_s1;
	assign push_data  = {grad, act_s1, ln, last_s1};

endmodule

/* rtl/core/cel_queue.sv */
// Small register queue between front and back ends.
module cel_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = cel_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_stall,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_stall,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_stall = (count_q == CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && !pop_stall;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* rtl/core/cel_back.sv */
// Back end: multiply, round and accumulate, then present gradient and loss.
module cel_back #(
	parameter int DATA_WIDTH = cel_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = cel_pkg::FRAC_BITS_DEF
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              pop_valid,
	output logic                                              pop_stall,
	input  logic [cel_pkg::q_width(DATA_WIDTH, FRAC_BITS)-1:0] pop_data,
	output logic                                              out_valid,
	input  logic                                              out_stall,
	output logic signed [DATA_WIDTH:0]                        gradient,
	output logic signed [cel_pkg::LOSS_W-1:0]                 loss,
	output logic                                              loss_valid
);

	localparam int Q_W    = cel_pkg::q_width(DATA_WIDTH, FRAC_BITS);
	localparam int LN_W   = cel_pkg::ln_width(FRAC_BITS);
	localparam int ACC_W  = cel_pkg::ACC_W;
	localparam int LOSS_W = cel_pkg::LOSS_W;
	localparam int PROD_W = DATA_WIDTH + LN_W;
	localparam int RND_W  = PROD_W + 1 - FRAC_BITS;
	localparam int SUM_W  = ((RND_W > ACC_W) ? RND_W : ACC_W) + 1;

	localparam logic signed [PROD_W:0] RND_HALF = (PROD_W + 1)'(64'd1 << (FRAC_BITS - 1));

	logic                          adv;
	logic signed [DATA_WIDTH:0]    grad_w;
	logic signed [DATA_WIDTH-1:0]  act_w;
	logic signed [LN_W-1:0]        ln_w;
	logic                          last_w;

	logic                          valid_s1;
	logic signed [PROD_W-1:0]      prod_s1;
	logic signed [DATA_WIDTH:0]    grad_s1;
	logic                          last_s1;

	logic signed [PROD_W:0]        rnd_add;
	logic signed [RND_W-1:0]       rnd;
	logic signed [SUM_W-1:0]       sum;
	logic signed [ACC_W-1:0]       sum_sat;
	logic signed [ACC_W-1:0]       acc_q;

	logic                          valid_s2;
	logic signed [ACC_W-1:0]       sum_s2;
	logic signed [DATA_WIDTH:0]    grad_s2;
	logic                          last_s2;

	logic signed [ACC_W:0]         neg;
	logic signed [LOSS_W-1:0]      loss_sat;

	logic                          out_valid_q;
	logic signed [DATA_WIDTH:0]    gradient_q;
	logic signed [LOSS_W-1:0]      loss_q;
	logic                          loss_valid_q;

	assign grad_w = pop_data[Q_W-1 -: DATA_WIDTH + 1];
	assign act_w  = pop_data[LN_W + DATA_WIDTH : LN_W + 1];
	assign ln_w   = pop_data[LN_W:1];
	assign last_w = pop_data[0];

	// the whole back end moves together whenever the output register frees
	assign adv       = !out_valid_q || !out_stall;
	assign pop_stall = !adv;

	// round half up to Q.16
	assign rnd_add = (PROD_W + 1)'(prod_s1) + RND_HALF;
	assign rnd     = RND_W'(rnd_add >>> FRAC_BITS);
	assign sum     = SUM_W'(rnd) + SUM_W'(acc_q);

	always_comb begin
		if ((&sum[SUM_W-1:ACC_W-1]) || !(|sum[SUM_W-1:ACC_W-1])) begin
			sum_sat = sum[ACC_W-1:0];
		end else if (sum[SUM_W-1]) begin
			sum_sat = {1'b1, {(ACC_W - 1){1'b0}}};
		end else begin
			sum_sat = {1'b0, {(ACC_W - 1){1'b1}}};
		end
	end

	assign neg = -((ACC_W + 1)'(sum_s2));

	always_comb begin
		if ((&neg[ACC_W:LOSS_W-1]) || !(|neg[ACC_W:LOSS_W-1])) begin
			loss_sat = neg[LOSS_W-1:0];
		end else if (neg[ACC_W]) begin
			loss_sat = {1'b1, {(LOSS_W - 1){1'b0}}};
		end else begin
			loss_sat = {1'b0, {(LOSS_W - 1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
		end else if (adv) begin
			valid_s1    <= pop_valid;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
			if (valid_s1) begin
				acc_q <= last_s1 ? '0 : sum_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1      <= act_w * ln_w;
			grad_s1      <= grad_w;
			last_s1      <= last_w;
			sum_s2       <= sum_sat;
			grad_s2      <= grad_s1;
			last_s2      <= last_s1;
			gradient_q   <= grad_s2;
			loss_q       <= last_s2 ? loss_sat : '0;
			loss_valid_q <= last_s2;
		end
	end

	assign out_valid  = out_valid_q;
	assign gradient   = gradient_q;
	assign loss       = loss_q;
	assign loss_valid = loss_valid_q;

endmodule

/* rtl/core/cel_checker.sv */
// Port-level checks on the cross-entropy block, bound to the top level.
module cel_checker #(
	parameter int DATA_WIDTH = cel_pkg::DATA_WIDTH_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic signed [DATA_WIDTH:0]        gradient,
	input logic signed [cel_pkg::LOSS_W-1:0] loss,
	input logic                              loss_valid
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(gradient) && $stable(loss)
			&& $stable(loss_valid))
		else $error("result changed while stalled");

	// loss is zero on every result that does not end a vector
	a_loss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !loss_valid |-> loss == '0)
		else $error("loss nonzero without loss_valid");

	// no result can appear at the first edge after reset
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid)
		else $error("result presented straight after reset");

	// an empty block takes a request at the first edge after reset
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !in_stall)
		else $error("request stalled straight after reset");

endmodule

bind cross_entropy_loss_gradient cel_checker #(
	.DATA_WIDTH (DATA_WIDTH)
) u_cel_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.gradient   (gradient),
	.loss       (loss),
	.loss_valid (loss_valid)
);

/* tb/tb_top.sv */
// Self-checking testbench for the cross-entropy loss and gradient block.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DW       = cel_pkg::DATA_WIDTH_DEF;
	localparam int FB       = cel_pkg::FRAC_BITS_DEF;
	localparam int LTB      = cel_pkg::LOG_TABLE_BITS_DEF;
	localparam int MINP     = cel_pkg::MIN_PREDICTION_DEF;
	localparam int GW       = DW + 1;
	localparam int LW       = cel_pkg::LOSS_W;
	localparam int LUT_SIZE = 1 << LTB;
	localparam int RANDOM_ITEMS = 1850;
	localparam int TAIL_ITEMS   = 200;

	localparam longint ACC_MAX  = (longint'(1) <<< (cel_pkg::ACC_W - 1)) - 1;
	localparam longint ACC_MIN  = -ACC_MAX - 1;
	localparam longint LOSS_MAX = (longint'(1) <<< (LW - 1)) - 1;
	localparam longint LOSS_MIN = -LOSS_MAX - 1;

	typedef struct {
		logic signed [DW-1:0] prediction;
		logic signed [DW-1:0] actual;
		logic                 last;
	} elem_req_t;

	typedef struct {
		logic signed [GW-1:0] gradient;
		logic signed [LW-1:0] loss;
		logic                 loss_valid;
	} grad_loss_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 in_stall;
	logic signed [DW-1:0] prediction   = '0;
	logic signed [DW-1:0] actual       = '0;
	logic                 last_element = 1'b0;
	logic                 out_valid;
	logic                 out_stall    = 1'b0;
	logic signed [GW-1:0] gradient;
	logic signed [LW-1:0] loss;
	logic                 loss_valid;

	logic hold_off   = 1'b0;
	logic tail_phase = 1'b0;

	elem_req_t  pending_reqs[$];
	grad_loss_t expected_results[$];
	longint     ln_lut[LUT_SIZE];
	longint     running_sum    = 0;
	int         accepted_total = 0;
	int         item_total     = 0;
	int         mismatch_count = 0;
	int         gap_left       = 0;
	int         stall_left     = 0;

	cross_entropy_loss_gradient DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.prediction   (prediction),
		.actual       (actual),
		.last_element (last_element),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.gradient     (gradient),
		.loss         (loss),
		.loss_valid   (loss_valid)
	);

	always #5 clk = ~clk;

	// ln of a clamped prediction in Q.16: exponent from the leading one, mantissa from the table
	function automatic longint ln_q16_of(input int pc);
		int k;
		int m;
		k = 0;
		while ((pc >> (k + 1)) != 0)
			k++;
		if (k >= LTB)
			m = pc >> (k - LTB);
		else
			m = pc << (LTB - k);
		m = m & (LUT_SIZE - 1);
		return longint'(k - FB) * cel_pkg::LN2_Q16 + ln_lut[m];
	endfunction

	function automatic grad_loss_t predict_grad_loss(input logic signed [DW-1:0] p,
			input logic signed [DW-1:0] a, input logic last);
		grad_loss_t r;
		longint pc;
		longint prod;
		longint sum;
		longint neg;
		r.gradient = GW'(longint'(p) - longint'(a));
		pc = longint'(p);
		if (pc < MINP)
			pc = MINP;
		if (pc > (longint'(1) <<< FB))
			pc = longint'(1) <<< FB;
		prod = longint'(a) * ln_q16_of(int'(pc));
		// round half up from Q.(FB+16) to Q.16
		prod = (prod + (longint'(1) <<< (FB - 1))) >>> FB;
		sum = running_sum + prod;
		if (sum > ACC_MAX)
			sum = ACC_MAX;
		if (sum < ACC_MIN)
			sum = ACC_MIN;
		running_sum = sum;
		if (last) begin
			neg = -running_sum;
			if (neg > LOSS_MAX)
				neg = LOSS_MAX;
			if (neg < LOSS_MIN)
				neg = LOSS_MIN;
			r.loss = LW'(neg);
			r.loss_valid = 1'b1;
			running_sum = 0;
		end else begin
			r.loss = '0;
			r.loss_valid = 1'b0;
		end
		return r;
	endfunction

	task automatic add_req(input int p, input int a, input bit last);
		elem_req_t req;
		req.prediction = DW'(p);
		req.actual = DW'(a);
		req.last = last;
		pending_reqs.push_back(req);
	endtask

	task automatic note_mismatch(input string field, input longint want, input longint got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin : feed
		elem_req_t req;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
			running_sum = 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(predict_grad_loss(prediction, actual, last_element));
				accepted_total++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					req = pending_reqs.pop_front();
					in_valid <= 1'b1;
					prediction <= req.prediction;
					actual <= req.actual;
					last_element <= req.last;
					if (!tail_phase && !hold_off && $urandom_range(0, 7) == 0)
						gap_left = $urandom_range(1, 16);
				end else begin
					in_valid <= 1'b0;
				end
			end
			tail_phase <= (pending_reqs.size() < TAIL_ITEMS);
		end
	end

	// result monitor and receiver stall
	always @(posedge clk or negedge arst_n) begin : watch
		grad_loss_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					note_mismatch("unexpected result, gradient", 0, longint'(gradient));
				end else begin
					want = expected_results.pop_front();
					if (gradient !== want.gradient)
						note_mismatch("gradient", longint'(want.gradient), longint'(gradient));
					if (loss !== want.loss)
						note_mismatch("loss", longint'(want.loss), longint'(loss));
					if (loss_valid !== want.loss_valid)
						note_mismatch("loss_valid", longint'(want.loss_valid),
							longint'(loss_valid));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (hold_off) begin
				out_stall <= 1'b1;
			end else if (!tail_phase && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 15);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// hold the output back long enough for the block to fill and stall its input
	initial begin
		wait (accepted_total >= 600);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (100) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#5_000_000;
		$display("[cross_entropy_loss_gradient] ERROR");
		$finish;
	end

	initial begin : main
		longint unsigned x;
		longint unsigned y;
		int tie_p;
		int vec_len;
		int sel;
		int p;
		int a;

		// log table: bitwise log2 of 1 + i/2^LTB, scaled by ln2, rounded to Q.16
		for (int i = 0; i < LUT_SIZE; i++) begin
			x = (64'd1 << 30) + (64'(i) << (30 - LTB));
			y = 0;
			for (int b = 1; b <= 32; b++) begin
				x = (x * x) >> 30;
				if (x >= (64'd2 << 30)) begin
					x = x >> 1;
					y = y | (64'd1 << (32 - b));
				end
			end
			ln_lut[i] = longint'((y * cel_pkg::LN2_Q32 + (64'd1 << 47)) >> 48);
		end

		// an odd log with actual = +/-2048 lands the product exactly on a rounding tie
		tie_p = 1;
		while (tie_p < 4096 && ln_q16_of(tie_p) % 2 == 0)
			tie_p++;

		add_req(0, 0, 0);
		add_req(-32768, 32767, 0);
		add_req(32767, -32768, 1);
		add_req(-32768, 32767, 1);
		add_req(1, 4096, 0);
		add_req(2, 4096, 0);
		add_req(4095, 4096, 0);
		add_req(4096, 4096, 0);
		add_req(4097, 4096, 1);
		add_req(tie_p, 2048, 0);
		add_req(tie_p, -2048, 1);
		add_req(255, 1000, 0);
		add_req(256, 1000, 0);
		add_req(511, 1000, 1);
		add_req(-1, -32768, 0);
		add_req(1, -32768, 1);
		add_req(1, 32767, 0);
		add_req(0, 32767, 0);
		add_req(-5, 32767, 1);
		add_req(2048, -1, 0);
		add_req(3000, 0, 1);

		item_total = pending_reqs.size() + RANDOM_ITEMS;
		while (pending_reqs.size() < item_total) begin
			vec_len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 60)
				: $urandom_range(1, 12);
			for (int j = 0; j < vec_len; j++) begin
				sel = $urandom_range(0, 9);
				if (sel < 6)
					p = $urandom_range(0, 4096);
				else if (sel < 7)
					p = $urandom_range(0, 63);
				else
					p = $urandom;
				a = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 4096) : $urandom;
				add_req(p, a, j == vec_len - 1);
			end
		end
		item_total = pending_reqs.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		wait (accepted_total == item_total);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("[cross_entropy_loss_gradient] OK");
		else
			$display("[cross_entropy_loss_gradient] ERROR");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/cel_pkg.sv
rtl/core/cel_front.sv
rtl/core/cel_queue.sv
rtl/core/cel_back.sv
rtl/core/cross_entropy_loss_gradient.sv
rtl/core/cel_checker.sv
tb/tb_top.sv
